@@ hw/rtl/tsm_pkg.sv @@
// Shared types, constants and PEC helpers for the thermistor scan monitor.
// No dependencies; used by every module of the block except tsm_fifo.
`default_nettype none

package tsm_pkg;

  // Default number of monitor ICs on the chain
  localparam int unsigned CHIPS_DEF   = 4;
  // Depth of the front/back queue and of the result queue
  localparam int unsigned QUEUE_DEPTH = 2;
  // Scan geometry
  localparam int unsigned MUX_COUNT   = 3;
  localparam logic [2:0]  LAST_CHAN   = 3'd7;
  localparam logic [2:0]  SKIP_CHAN   = 3'd4;
  localparam logic [15:0] TEMP_MAX    = 16'hFFFF;

  // PEC: 15-bit CRC, poly 0x4599, seed 16, 48 message bits
  localparam int unsigned PEC_BITS = 48;
  localparam logic [14:0] PEC_POLY = 15'h4599;
  localparam logic [14:0] PEC_SEED = 15'd16;

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_OVERTEMP  = 1'b0,
    REG_UNDERTEMP = 1'b1
  } cfg_reg_e;

  // Classified readout handed from front to back
  typedef struct packed {
    logic [1:0]       mux;
    logic [2:0]       chan;
    logic [3:0]       chip;
    logic             first;
    logic             last;
    logic             rearm;
    logic [3:0]       use_mask;
    logic [3:0][15:0] reading;
    logic [1:0]       pec_errs;
  } item_t;

  // One result word
  typedef struct packed {
    logic [4:0]  scan_position;
    logic [3:0]  chip_number;
    logic [15:0] coldest_reading;
    logic [15:0] hottest_reading;
    logic [5:0]  pec_fail_count;
    logic [31:0] overtemp_count;
    logic [31:0] undertemp_count;
    logic        step_done;
  } result_t;

  // One CRC shift step, message bit in
  function automatic logic [14:0] pec_step(logic [14:0] rem, logic din);
    logic fb;
    fb = rem[14] ^ din;
    return fb ? ({rem[13:0], 1'b0} ^ PEC_POLY) : {rem[13:0], 1'b0};
  endfunction

  // Remainder contributed by each message bit alone (seed zero).
  // Bit 47 of the message is shifted in first.
  function automatic logic [PEC_BITS-1:0][14:0] pec_columns();
    logic [PEC_BITS-1:0][14:0] cols;
    logic [14:0]               rem;
    for (int k = 0; k < PEC_BITS; k++) begin
      rem = '0;
      for (int i = PEC_BITS - 1; i >= 0; i--) begin
        rem = pec_step(rem, (i == k));
      end
      cols[k] = rem;
    end
    return cols;
  endfunction

  // Remainder of the seed over an all-zero message
  function automatic logic [14:0] pec_seed_term();
    logic [14:0] rem;
    rem = PEC_SEED;
    for (int i = 0; i < PEC_BITS; i++) begin
      rem = pec_step(rem, 1'b0);
    end
    return rem;
  endfunction

  localparam logic [PEC_BITS-1:0][14:0] PEC_COLS = pec_columns();
  localparam logic [14:0]               PEC_INIT = pec_seed_term();

  // CRC is linear: seed term XOR the columns of the set message bits
  function automatic logic [15:0] pec_calc(logic [PEC_BITS-1:0] msg);
    logic [14:0] rem;
    rem = PEC_INIT;
    for (int k = 0; k < PEC_BITS; k++) begin
      if (msg[k]) begin
        rem = rem ^ PEC_COLS[k];
      end
    end
    return {rem, 1'b0};
  endfunction

  // Mismatch flag for one register group (low byte of each word first)
  function automatic logic pec_bad(logic [15:0] w0, logic [15:0] w1,
                                   logic [15:0] w2, logic [15:0] rx);
    logic [PEC_BITS-1:0] msg;
    msg = {w0[7:0], w0[15:8], w1[7:0], w1[15:8], w2[7:0], w2[15:8]};
    return pec_calc(msg) != rx;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/tsm_fifo.sv @@
// Small first-word-fall-through queue of register slots.
// Depends on nothing; used twice by the top level.
`default_nettype none

module tsm_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      rdata_o,
  output logic                  empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = slot_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + CW'(1);
      2'b01:   count_d = count_q - CW'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // data slots, no reset
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/tsm_front.sv @@
// Front end: tracks scan position and IC, applies skip rules, checks PECs.
// Depends on tsm_pkg.
`default_nettype none

module tsm_front #(
  parameter int unsigned CHIPS = tsm_pkg::CHIPS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_i,
  input  wire logic        q_full_i,
  input  wire logic [15:0] group_a_word0_i,
  input  wire logic [15:0] group_a_word1_i,
  input  wire logic [15:0] group_a_word2_i,
  input  wire logic [15:0] group_c_word0_i,
  input  wire logic [15:0] group_c_word1_i,
  input  wire logic [15:0] group_c_word2_i,
  input  wire logic [15:0] pec_a_received_i,
  input  wire logic [15:0] pec_c_received_i,
  output logic             item_valid_o,
  output tsm_pkg::item_t   item_o
);

  logic [1:0] mux_q, mux_d;
  logic [2:0] chan_q, chan_d;
  logic [3:0] chip_q, chip_d;
  logic       accept, first, last, pec_a_bad, pec_c_bad;

  assign accept       = push_i && !q_full_i;
  assign item_valid_o = accept;
  assign first        = (chip_q == 4'd0);
  assign last         = (chip_q >= 4'(CHIPS - 1));

  // PEC checks of both register groups
  assign pec_a_bad = tsm_pkg::pec_bad(group_a_word0_i, group_a_word1_i,
                                      group_a_word2_i, pec_a_received_i);
  assign pec_c_bad = tsm_pkg::pec_bad(group_c_word0_i, group_c_word1_i,
                                      group_c_word2_i, pec_c_received_i);

  // classify the readout
  always_comb begin
    item_o          = '0;
    item_o.mux      = mux_q;
    item_o.chan     = chan_q;
    item_o.chip     = chip_q;
    item_o.first    = first;
    item_o.last     = last;
    item_o.rearm    = first && (mux_q == 2'd0) && (chan_q == tsm_pkg::LAST_CHAN);
    // a0: not on mux 0 below channel 7; not on IC 0 at channel 7 of mux 0 or 2
    item_o.use_mask[0] = ((mux_q != 2'd0) || (chan_q == tsm_pkg::LAST_CHAN)) &&
                         !(first && (chan_q == tsm_pkg::LAST_CHAN) &&
                           ((mux_q == 2'd0) || (mux_q == 2'd2)));
    // a1: broken on IC 1, mux 2, channel 4
    item_o.use_mask[1] = !((chip_q == 4'd1) && (mux_q == 2'd2) &&
                           (chan_q == tsm_pkg::SKIP_CHAN));
    // a2: broken on IC 1, mux 1, channel 4
    item_o.use_mask[2] = !((chip_q == 4'd1) && (mux_q == 2'd1) &&
                           (chan_q == tsm_pkg::SKIP_CHAN));
    // c0: only upper channels of mux 0
    item_o.use_mask[3] = (mux_q != 2'd0) || (chan_q >= tsm_pkg::SKIP_CHAN);
    item_o.reading     = {group_c_word0_i, group_a_word2_i,
                          group_a_word1_i, group_a_word0_i};
    item_o.pec_errs    = {1'b0, pec_a_bad} + {1'b0, pec_c_bad};
  end

  // scan position advance
  always_comb begin
    mux_d  = mux_q;
    chan_d = chan_q;
    chip_d = chip_q;
    if (accept) begin
      if (last) begin
        chip_d = 4'd0;
        chan_d = chan_q + 3'd1;
        if (chan_q == tsm_pkg::LAST_CHAN) begin
          mux_d = (mux_q >= 2'(tsm_pkg::MUX_COUNT - 1)) ? 2'd0 : mux_q + 2'd1;
        end
      end else begin
        chip_d = chip_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mux_q  <= '0;
      chan_q <= '0;
      chip_q <= '0;
    end else begin
      mux_q  <= mux_d;
      chan_q <= chan_d;
      chip_q <= chip_d;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/tsm_back.sv @@
// Back end: extremes, PEC fail count and threshold counters.
// Depends on tsm_pkg.
`default_nettype none

module tsm_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           item_valid_i,
  input  wire tsm_pkg::item_t item_i,
  input  wire logic           res_full_i,
  input  wire logic [15:0]    over_thr_i,
  input  wire logic [15:0]    under_thr_i,
  output logic                item_pop_o,
  output logic                res_valid_o,
  output tsm_pkg::result_t    res_o
);

  logic [15:0] coldest_q, coldest_d, hottest_q, hottest_d;
  logic [31:0] over_q, over_d, under_q, under_d;
  logic [5:0]  pec_q, pec_d;
  logic [15:0] cold_base, hot_base;
  logic [3:0][15:0] hi, lo;
  logic [15:0] hi01, hi23, hi_max, lo01, lo23, lo_min;
  logic        take;

  assign take        = item_valid_i && !res_full_i;
  assign item_pop_o  = take;
  assign res_valid_o = take;

  // unused readings drop out of the max/min
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      hi[i] = item_i.use_mask[i] ? item_i.reading[i] : 16'd0;
      lo[i] = item_i.use_mask[i] ? item_i.reading[i] : tsm_pkg::TEMP_MAX;
    end
  end

  // max/min trees
  assign hi01   = (hi[1] > hi[0]) ? hi[1] : hi[0];
  assign hi23   = (hi[3] > hi[2]) ? hi[3] : hi[2];
  assign hi_max = (hi23 > hi01) ? hi23 : hi01;
  assign lo01   = (lo[1] < lo[0]) ? lo[1] : lo[0];
  assign lo23   = (lo[3] < lo[2]) ? lo[3] : lo[2];
  assign lo_min = (lo23 < lo01) ? lo23 : lo01;

  // re-arm at the start of mux 0 channel 7
  assign cold_base = item_i.rearm ? 16'd0 : coldest_q;
  assign hot_base  = item_i.rearm ? tsm_pkg::TEMP_MAX : hottest_q;

  always_comb begin
    coldest_d = (hi_max > cold_base) ? hi_max : cold_base;
    hottest_d = (lo_min < hot_base) ? lo_min : hot_base;
    pec_d     = (item_i.first ? 6'd0 : pec_q) + {4'd0, item_i.pec_errs};
    over_d    = over_q;
    under_d   = under_q;
    // thresholds tested once per step
    if (item_i.last) begin
      if (hottest_d < over_thr_i) begin
        over_d = over_q + 32'd1;
      end
      if (coldest_d > under_thr_i) begin
        under_d = under_q + 32'd1;
      end
    end
  end

  always_comb begin
    res_o                 = '0;
    res_o.scan_position   = {item_i.mux, item_i.chan};
    res_o.chip_number     = item_i.chip;
    res_o.coldest_reading = coldest_d;
    res_o.hottest_reading = hottest_d;
    res_o.pec_fail_count  = pec_d;
    res_o.overtemp_count  = over_d;
    res_o.undertemp_count = under_d;
    res_o.step_done       = item_i.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coldest_q <= '0;
      hottest_q <= tsm_pkg::TEMP_MAX;
      over_q    <= '0;
      under_q   <= '0;
      pec_q     <= '0;
    end else if (take) begin
      coldest_q <= coldest_d;
      hottest_q <= hottest_d;
      over_q    <= over_d;
      under_q   <= under_d;
      pec_q     <= pec_d;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/thermistor_scan_monitor_core.sv @@
// Top level of the thermistor scan monitor: config registers, front, back, queues.
// Depends on tsm_pkg, tsm_fifo, tsm_front, tsm_back.
//
// Usage: each readout word is one monitor IC's auxiliary data (groups A and C plus
// both received PECs), pushed with push while full is low. ICs of one scan step
// come in order 0..CHIPS-1; the block tracks mux/channel/IC itself. Every readout
// yields one result word, popped with pop while empty is low; the oldest result
// is always on the result ports.
// A pushed word reaches the result ports through two register stages: the
// front/back queue and the result queue.
// Throughput: one word per cycle while the result queue has room, as the back end
// updates the extremes and counters as it takes each word.
// Reset clears scan position, extremes (coldest 0, hottest 0xFFFF), counters,
// thresholds (over 0, under 0xFFFF) and both queues.
// When the receiver stalls the result queue fills, the back end holds, the
// front/back queue fills and full rises; nothing is dropped. The user must
// write thresholds via cfg_we_i/cfg_idx_i/cfg_wdata_i only while idle; unenforced.
`default_nettype none

module thermistor_scan_monitor_core #(
  parameter int unsigned CHIPS = tsm_pkg::CHIPS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // config
  input  wire logic        cfg_we_i,
  input  wire logic [0:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_wdata_i,
  // readout in
  input  wire logic        push,
  output logic             full,
  input  wire logic [15:0] group_a_word0_i,
  input  wire logic [15:0] group_a_word1_i,
  input  wire logic [15:0] group_a_word2_i,
  input  wire logic [15:0] group_c_word0_i,
  input  wire logic [15:0] group_c_word1_i,
  input  wire logic [15:0] group_c_word2_i,
  input  wire logic [15:0] pec_a_received_i,
  input  wire logic [15:0] pec_c_received_i,
  // results out
  output logic             empty,
  input  wire logic        pop,
  output logic [4:0]       scan_position_o,
  output logic [3:0]       chip_number_o,
  output logic [15:0]      coldest_reading_o,
  output logic [15:0]      hottest_reading_o,
  output logic [5:0]       pec_fail_count_o,
  output logic [31:0]      overtemp_count_o,
  output logic [31:0]      undertemp_count_o,
  output logic             step_done_o
);

  localparam int unsigned ITEM_W = $bits(tsm_pkg::item_t);
  localparam int unsigned RES_W  = $bits(tsm_pkg::result_t);

  logic [15:0]      over_thr_q, under_thr_q;
  tsm_pkg::item_t   front_item, back_item;
  tsm_pkg::result_t back_res, out_res;
  logic             front_valid, mid_full, mid_empty, mid_pop;
  logic             res_valid, res_full;

  // threshold registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      over_thr_q  <= '0;
      under_thr_q <= tsm_pkg::TEMP_MAX;
    end else if (cfg_we_i) begin
      case (tsm_pkg::cfg_reg_e'(cfg_idx_i))
        tsm_pkg::REG_OVERTEMP:  over_thr_q  <= cfg_wdata_i;
        tsm_pkg::REG_UNDERTEMP: under_thr_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  tsm_front #(
    .CHIPS(CHIPS)
  ) u_front (
    .clk_i,
    .rst_ni,
    .push_i          (push),
    .q_full_i        (mid_full),
    .group_a_word0_i,
    .group_a_word1_i,
    .group_a_word2_i,
    .group_c_word0_i,
    .group_c_word1_i,
    .group_c_word2_i,
    .pec_a_received_i,
    .pec_c_received_i,
    .item_valid_o    (front_valid),
    .item_o          (front_item)
  );

  assign full = mid_full;

  // front to back queue
  tsm_fifo #(
    .WIDTH(ITEM_W),
    .DEPTH(tsm_pkg::QUEUE_DEPTH)
  ) u_mid_q (
    .clk_i,
    .rst_ni,
    .push_i  (front_valid),
    .wdata_i (front_item),
    .full_o  (mid_full),
    .pop_i   (mid_pop),
    .rdata_o (back_item),
    .empty_o (mid_empty)
  );

  tsm_back u_back (
    .clk_i,
    .rst_ni,
    .item_valid_i (!mid_empty),
    .item_i       (back_item),
    .res_full_i   (res_full),
    .over_thr_i   (over_thr_q),
    .under_thr_i  (under_thr_q),
    .item_pop_o   (mid_pop),
    .res_valid_o  (res_valid),
    .res_o        (back_res)
  );

  // result queue
  tsm_fifo #(
    .WIDTH(RES_W),
    .DEPTH(tsm_pkg::QUEUE_DEPTH)
  ) u_res_q (
    .clk_i,
    .rst_ni,
    .push_i  (res_valid),
    .wdata_i (back_res),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (out_res),
    .empty_o (empty)
  );

  assign scan_position_o   = out_res.scan_position;
  assign chip_number_o     = out_res.chip_number;
  assign coldest_reading_o = out_res.coldest_reading;
  assign hottest_reading_o = out_res.hottest_reading;
  assign pec_fail_count_o  = out_res.pec_fail_count;
  assign overtemp_count_o  = out_res.overtemp_count;
  assign undertemp_count_o = out_res.undertemp_count;
  assign step_done_o       = out_res.step_done;

  // step end is flagged exactly on the last IC
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (step_done_o == (chip_number_o == 4'(CHIPS - 1))))
    else $error("step_done does not match last IC");

  // at most two PEC failures per IC within one step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (pec_fail_count_o <= ({1'b0, chip_number_o, 1'b0} + 6'd2)))
    else $error("PEC fail count exceeds two per IC");

  // scan position stays within three muxes of eight channels
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (scan_position_o < 5'd24))
    else $error("scan position out of range");

endmodule

`default_nettype wire
